/* rtl/u16pe_pkg.sv */
// ----------------------------------------------------------------------------
// u16pe_pkg
// Shared types for the UTF-16 to percent-encoded UTF-8 converter.
// ----------------------------------------------------------------------------
package u16pe_pkg;

  // One UTF-8 sequence queued between the front and the back.
  typedef struct packed {
    logic [3:0][7:0] bytes;   // byte 0 is sent first
    logic [1:0]      nb_m1;   // number of bytes minus one
    logic            last;    // sequence closes the run of its input item
  } job_t;

  localparam int unsigned JobW = $bits(job_t);

endpackage

/* rtl/u16pe_fifo.sv */
// ----------------------------------------------------------------------------
// u16pe_fifo
// Small register queue that decouples the classifying front from the back.
// ----------------------------------------------------------------------------
module u16pe_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             wr_ready_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             rd_valid_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && wr_ready_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue fill count exceeds its depth");

endmodule

/* rtl/u16pe_front.sv */
// ----------------------------------------------------------------------------
// u16pe_front
// Accepts code units, pairs surrogates and queues the UTF-8 byte sequences.
// ----------------------------------------------------------------------------
module u16pe_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,   // [15:0] code_unit
  input  logic              s_axis_tlast,   // string_end
  output logic              push_o,
  output u16pe_pkg::job_t   push_data_o,
  input  logic              push_ready_i
);

  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;

  function automatic u16pe_pkg::job_t encode(input logic [20:0] cp, input logic last);
    u16pe_pkg::job_t j;
    j.bytes = '0;
    j.last  = last;
    if (cp < 21'h80) begin
      j.nb_m1    = 2'd0;
      j.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      j.nb_m1    = 2'd1;
      j.bytes[0] = {3'b110, cp[10:6]};
      j.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      j.nb_m1    = 2'd2;
      j.bytes[0] = {4'b1110, cp[15:12]};
      j.bytes[1] = {2'b10, cp[11:6]};
      j.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      j.nb_m1    = 2'd3;
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
    end
    return j;
  endfunction

  logic            held_q, held_d;
  logic [9:0]      bits_q, bits_d;
  logic            pend_q, pend_d;
  u16pe_pkg::job_t pend_job_q, pend_job_d;

  logic            accept, is_low, is_high, hold_new;
  u16pe_pkg::job_t job_pair, job_flush, job_cur;

  assign is_low   = (s_axis_tdata[15:10] == LowTag);
  assign is_high  = (s_axis_tdata[15:10] == HighTag);
  assign hold_new = is_high && !s_axis_tlast;

  assign s_axis_tready = push_ready_i && !pend_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign job_pair  = encode(21'h10000 + {1'b0, bits_q, s_axis_tdata[9:0]}, 1'b1);
  assign job_flush = encode({5'd0, HighTag, bits_q}, hold_new);
  assign job_cur   = encode({5'd0, s_axis_tdata}, 1'b1);

  always_comb begin
    held_d      = held_q;
    bits_d      = bits_q;
    pend_d      = pend_q;
    pend_job_d  = pend_job_q;
    push_o      = 1'b0;
    push_data_o = job_cur;
    if (pend_q) begin
      push_o      = 1'b1;
      push_data_o = pend_job_q;
      if (push_ready_i) begin
        pend_d = 1'b0;
      end
    end else if (accept) begin
      held_d = hold_new;
      if (hold_new) begin
        bits_d = s_axis_tdata[9:0];
      end
      if (held_q) begin
        push_o      = 1'b1;
        push_data_o = is_low ? job_pair : job_flush;
        if (!is_low && !hold_new) begin
          pend_d     = 1'b1;
          pend_job_d = job_cur;
        end
      end else begin
        push_o = !hold_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      bits_q <= '0;
      pend_q <= 1'b0;
    end else begin
      held_q <= held_d;
      bits_q <= bits_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_job_q <= pend_job_d;
  end

  a_pend_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !held_q)
    else $error("a deferred unit coexists with a held surrogate");

endmodule

/* rtl/u16pe_back.sv */
// ----------------------------------------------------------------------------
// u16pe_back
// Turns queued UTF-8 sequences into ASCII, one character per unstalled cycle.
// ----------------------------------------------------------------------------
module u16pe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  u16pe_pkg::job_t   pop_data_i,
  output logic              pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [6:0] out_char, [7] zero fill
  output logic              m_axis_tlast    // run_last
);

  localparam logic [6:0] Percent = 7'h25;

  function automatic logic is_unreserved(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
           b == 8'h2E || b == 8'h7E;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (7'h30 + {3'd0, n}) : (7'h37 + {3'd0, n});
  endfunction

  logic            job_valid_q, job_valid_d;
  u16pe_pkg::job_t job_q, job_d;
  logic [1:0]      idx_q, idx_d;
  logic [1:0]      ph_q, ph_d;
  logic            out_valid_q, out_valid_d;
  logic [6:0]      out_char_q, out_char_d;
  logic            out_last_q, out_last_d;

  logic       slot_free, emit, byte_done, job_done;
  logic [7:0] cur_byte;
  logic       cur_lit;
  logic [6:0] char_sel;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign emit      = job_valid_q && slot_free;
  assign cur_byte  = job_q.bytes[idx_q];
  assign cur_lit   = is_unreserved(cur_byte);
  assign byte_done = cur_lit || (ph_q == 2'd2);
  assign job_done  = byte_done && (idx_q == job_q.nb_m1);
  assign pop_o     = pop_valid_i && (!job_valid_q || (emit && job_done));

  always_comb begin
    case (ph_q)
      2'd0:    char_sel = cur_lit ? cur_byte[6:0] : Percent;
      2'd1:    char_sel = hex_char(cur_byte[7:4]);
      2'd2:    char_sel = hex_char(cur_byte[3:0]);
      default: char_sel = Percent;
    endcase
  end

  always_comb begin
    job_valid_d = job_valid_q;
    job_d       = job_q;
    idx_d       = idx_q;
    ph_d        = ph_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = char_sel;
      out_last_d  = job_done && job_q.last;
      if (byte_done) begin
        idx_d = idx_q + 2'd1;
        ph_d  = 2'd0;
      end else begin
        ph_d = ph_q + 2'd1;
      end
      if (job_done) begin
        job_valid_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      job_valid_d = 1'b1;
      job_d       = pop_data_i;
      idx_d       = 2'd0;
      ph_d        = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_char_q};
  assign m_axis_tlast  = out_last_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (idx_q <= job_q.nb_m1))
    else $error("byte index runs past the sequence length");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && (ph_q != 2'd0) |-> !is_unreserved(cur_byte) && (ph_q != 2'd3))
    else $error("escape phase on a literal byte or out of range");

endmodule

/* rtl/utf16_to_percent_encoded_utf8_core.sv */
// ----------------------------------------------------------------------------
// utf16_to_percent_encoded_utf8_core
// Converts UTF-16 code units to percent-encoded UTF-8 text, one character per output beat.
// ----------------------------------------------------------------------------
// An item's first character passes the queue and the job register on its way to the output.
// The output delivers one character per cycle while the receiver is ready. A unit yields
// one to nine characters, a surrogate pair twelve, and a unit that flushes a held
// surrogate up to eighteen; the front holds off input while queueing that unit's own bytes.
// Reset clears the held surrogate, the queue and the output register.
module utf16_to_percent_encoded_utf8_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // string_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero fill
  output logic        m_axis_tlast    // run_last
);

  logic            push, push_ready, pop, pop_valid;
  u16pe_pkg::job_t push_data, pop_data;

  u16pe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push_o        (push),
    .push_data_o   (push_data),
    .push_ready_i  (push_ready)
  );

  u16pe_fifo #(
    .Width (u16pe_pkg::JobW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_data_i  (push_data),
    .wr_ready_o (push_ready),
    .rd_en_i    (pop),
    .rd_data_o  (pop_data),
    .rd_valid_o (pop_valid)
  );

  u16pe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* sim/tb_utf16_to_percent_encoded_utf8_core.sv */
// ----------------------------------------------------------------------------
// tb_utf16_to_percent_encoded_utf8_core
// Self-checking testbench for the UTF-16 to percent-encoded UTF-8 converter.
// A short table of directed units comes first. Some rows carry the expected
// text typed in, and the others are checked against a behavioral encoder.
// Random strings follow; a quarter of draws are surrogate pairs, the rest
// single units. The sender works in bursts, the receiver stalls in shifting
// patterns. Every output character is compared with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_utf16_to_percent_encoded_utf8_core;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;
  localparam logic [6:0]  PctChar   = 7'h25;
  localparam int          RandUnits = 225;
  localparam int          TailWait  = 40;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_exp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'h0000;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  logic [15:0] row_cu[$];
  logic        row_end[$];
  string       row_txt[$];

  logic        held_vld  = 1'b0;
  logic [9:0]  held_bits = 10'd0;
  char_exp_t   run_q[$];
  char_exp_t   char_q[$];
  char_exp_t   ce;
  int          acc_cnt = 0;
  int          errs    = 0;
  int          k;
  logic [7:0]  txt_byte;

  logic [15:0] rx_cyc  = 16'd0;
  int          rx_mode = 0;

  utf16_to_percent_encoded_utf8_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic is_unreserved(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
           b == "-" || b == "_" || b == "." || b == "~";
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return 7'h30 + 7'(n);
    end
    return 7'h37 + 7'(n);
  endfunction

  task automatic push_char(input logic [6:0] c);
    char_exp_t e;
    e.ch   = c;
    e.last = 1'b0;
    run_q.push_back(e);
  endtask

  task automatic push_byte(input logic [7:0] b);
    if (is_unreserved(b)) begin
      push_char(b[6:0]);
    end else begin
      push_char(PctChar);
      push_char(hex_char(b[7:4]));
      push_char(hex_char(b[3:0]));
    end
  endtask

  task automatic push_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endtask

  // Encodes one code unit into run_q and advances the surrogate hold.
  task automatic encode_unit(input logic [15:0] cu, input logic fin);
    logic      is_lo;
    logic      is_hi;
    char_exp_t e;
    is_lo = (cu >= LowFirst) && (cu <= LowLast);
    is_hi = (cu >= HighFirst) && (cu <= HighLast);
    run_q.delete();
    if (held_vld && is_lo) begin
      push_code_point(21'h10000 + {1'b0, held_bits, cu[9:0]});
      held_vld  = 1'b0;
      held_bits = 10'd0;
    end else begin
      if (held_vld) begin
        push_code_point({5'd0, HighFirst[15:10], held_bits});
        held_vld  = 1'b0;
        held_bits = 10'd0;
      end
      if (is_hi && !fin) begin
        held_bits = cu[9:0];
        held_vld  = 1'b1;
      end else begin
        push_code_point({5'd0, cu});
      end
    end
    if (run_q.size() > 0) begin
      e = run_q.pop_back();
      e.last = 1'b1;
      run_q.push_back(e);
    end
  endtask

  task automatic add_row(input logic [15:0] cu, input logic fin, input string txt);
    row_cu.push_back(cu);
    row_end.push_back(fin);
    row_txt.push_back(txt);
  endtask

  // The receiver switches between stall patterns, picking one whenever rx_cyc[7:0] is zero.
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 16'd1;
    if (rx_cyc[7:0] == 8'd0) begin
      rx_mode <= $urandom_range(0, 3);
    end
    case (rx_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= (rx_cyc[1:0] == 2'd0);
      end
      default: begin
        m_axis_tready <= (rx_cyc[3:0] < 4'd3);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      encode_unit(s_axis_tdata, s_axis_tlast);
      if (row_txt[acc_cnt].len() != 0) begin
        for (k = 0; k < row_txt[acc_cnt].len(); k++) begin
          txt_byte = row_txt[acc_cnt].getc(k);
          ce.ch    = txt_byte[6:0];
          ce.last  = (k == row_txt[acc_cnt].len() - 1);
          char_q.push_back(ce);
        end
      end else begin
        for (k = 0; k < run_q.size(); k++) begin
          char_q.push_back(run_q[k]);
        end
      end
      acc_cnt++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (char_q.size() == 0) begin
        $error("unexpected character 0x%02h", m_axis_tdata);
        errs++;
      end else begin
        ce = char_q.pop_front();
        if (m_axis_tdata !== {1'b0, ce.ch}) begin
          $error("out_char: expected 0x%02h, got 0x%02h", {1'b0, ce.ch}, m_axis_tdata);
          errs++;
        end
        if (m_axis_tlast !== ce.last) begin
          $error("run_last: expected %0b, got %0b", ce.last, m_axis_tlast);
          errs++;
        end
      end
    end
  end

  initial begin
    int          i;
    int          burst_len;
    int          gap_len;
    int          kind;
    int          r;
    logic [15:0] cu;

    add_row(16'h0041, 1'b0, "A");
    add_row(16'h0000, 1'b0, "%00");
    add_row(16'h007F, 1'b0, "%7F");
    add_row(16'h0020, 1'b0, "%20");
    add_row(16'h002D, 1'b0, "-");
    add_row(16'h005F, 1'b0, "_");
    add_row(16'h002E, 1'b0, ".");
    add_row(16'h007E, 1'b0, "~");
    add_row(16'h0030, 1'b0, "0");
    add_row(16'h007A, 1'b0, "z");
    add_row(16'h0080, 1'b0, "%C2%80");
    add_row(16'h07FF, 1'b0, "%DF%BF");
    add_row(16'h0800, 1'b0, "%E0%A0%80");
    add_row(16'hFFFF, 1'b1, "%EF%BF%BF");
    add_row(16'hD800, 1'b0, "");
    add_row(16'hDC00, 1'b1, "%F0%90%80%80");
    add_row(16'hDBFF, 1'b0, "");
    add_row(16'hDFFF, 1'b0, "%F4%8F%BF%BF");
    add_row(16'hDC00, 1'b0, "%ED%B0%80");
    add_row(16'hDBFF, 1'b1, "%ED%AF%BF");
    add_row(16'hD83D, 1'b0, "");
    add_row(16'hD83D, 1'b1, "%ED%A0%BD%ED%A0%BD");
    add_row(16'hD800, 1'b0, "");
    add_row(16'h0041, 1'b1, "%ED%A0%80A");
    add_row(16'hD801, 1'b0, "");

    i = row_cu.size() + RandUnits;
    while (row_cu.size() < i) begin
      kind = $urandom_range(0, 11);
      if (kind <= 2) begin
        add_row(16'($urandom_range(HighFirst, HighLast)), 1'b0, "");
        add_row(16'($urandom_range(LowFirst, LowLast)),
                ($urandom_range(0, 3) == 0), "");
      end else begin
        case (kind)
          3: cu = 16'($urandom_range(HighFirst, HighLast));
          4: cu = 16'($urandom_range(LowFirst, LowLast));
          5, 6: cu = 16'($urandom_range(0, 127));
          7: begin
            r = $urandom_range(0, 65);
            if (r < 26) begin
              cu = 16'("A" + r);
            end else if (r < 52) begin
              cu = 16'("a" + r - 26);
            end else if (r < 62) begin
              cu = 16'("0" + r - 52);
            end else begin
              case (r)
                62: cu = 16'("-");
                63: cu = 16'("_");
                64: cu = 16'(".");
                default: cu = 16'("~");
              endcase
            end
          end
          8: cu = 16'($urandom_range(16'h0080, 16'h07FF));
          9, 10: cu = 16'($urandom_range(16'h0800, 16'hFFFF));
          default: cu = 16'($urandom_range(0, 65535));
        endcase
        add_row(cu, ($urandom_range(0, 5) == 0), "");
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    i = 0;
    while (i < row_cu.size()) begin
      burst_len = $urandom_range(1, 16);
      while (burst_len > 0 && i < row_cu.size()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row_cu[i];
        s_axis_tlast  <= row_end[i];
        @(posedge clk_i);
        while (!s_axis_tready) @(posedge clk_i);
        i++;
        burst_len--;
      end
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (errs == 0) begin
      $display("utf16_to_percent_encoded_utf8_core: match");
    end else begin
      $display("utf16_to_percent_encoded_utf8_core: mismatch");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("utf16_to_percent_encoded_utf8_core: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/u16pe_pkg.sv
rtl/u16pe_fifo.sv
rtl/u16pe_front.sv
rtl/u16pe_back.sv
rtl/utf16_to_percent_encoded_utf8_core.sv
sim/tb_utf16_to_percent_encoded_utf8_core.sv
